// ----- rtl/mss_pkg.sv -----
// Package for the MIDI step sequencer: sizes, function and message codes,
// and the item, result and push structures used by the core, queue and top.
// No dependencies.
package mss_pkg;

    // Pattern length and derived widths
    localparam int NUM_STEPS  = 16;
    localparam int POS_W      = $clog2(NUM_STEPS);
    localparam int SIDX_W     = 5;
    localparam int SIDX_EXT_W = (POS_W > SIDX_W) ? POS_W : SIDX_W;
    localparam int POSITION_W = 4;
    localparam int POS_EXT_W  = (POS_W > POSITION_W) ? POS_W : POSITION_W;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int OFFSET_W = 8;
    localparam int NOTE_W   = 7;
    localparam int KIND_W   = 2;
    localparam int SUM_W    = OFFSET_W + 1;

    localparam logic [NOTE_W-1:0] NOTE_MAX   = 7'd127;
    localparam logic [NOTE_W-1:0] BASE_RESET = 7'd60;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PLAY  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RESET = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd4;

    // Result message kinds
    localparam logic [KIND_W-1:0] KIND_OFF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ON   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic [SIDX_W-1:0]          step_index;
        logic signed [OFFSET_W-1:0] note_offset;
        logic                       gate_in;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]     msg_kind;
        logic [NOTE_W-1:0]     note;
        logic [POSITION_W-1:0] position;
        logic                  last_of_run;
    } t_result;

    // Results of one item handed from the core to the queue
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- rtl/mss_ifs.sv -----
// Handshake interfaces of the MIDI step sequencer: input words, result
// words and the base-note configuration write. Depends on mss_pkg.
interface mss_in_if;
    logic                                         valid;
    logic                                         ready;
    logic [mss_pkg::FUNC_W-1:0]                   func;
    logic [mss_pkg::SIDX_W-1:0]                   step_index;
    logic signed [mss_pkg::OFFSET_W-1:0]          note_offset;
    logic                                         gate_in;

    modport source (output valid, func, step_index, note_offset, gate_in, input ready);
    modport sink   (input valid, func, step_index, note_offset, gate_in, output ready);
endinterface

interface mss_out_if;
    logic                              valid;
    logic                              ready;
    logic [mss_pkg::KIND_W-1:0]        msg_kind;
    logic [mss_pkg::NOTE_W-1:0]        note;
    logic [mss_pkg::POSITION_W-1:0]    position;
    logic                              last_of_run;

    modport source (output valid, msg_kind, note, position, last_of_run, input ready);
    modport sink   (input valid, msg_kind, note, position, last_of_run, output ready);
endinterface

interface mss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mss_pkg::NOTE_W-1:0]    base_note;

    modport source (output valid, base_note, input ready);
    modport sink   (input valid, base_note, output ready);
endinterface

// ----- rtl/midi_step_sequencer.sv -----
// Top level of the MIDI step sequencer: core plus result queue.
// Depends on mss_pkg, mss_ifs, mss_core and mss_outq.
//
// Usage: i_item carries one command word (tick, play, stop, reset, pattern
// write) per valid/ready handshake. o_result carries note-off, note-on and
// step-marker words; last_of_run marks the final word caused by a command.
// i_cfg writes the base note and is always ready; write it only while idle.
// An accepted command is held in the core's input register until the
// result queue has room; its results then go into the queue, whose head
// word drives o_result. Throughput: one command per cycle when it gives no
// result and the queue has room; results leave at one word per cycle
// through the output port while the receiver is ready. The core fires when
// the four-word result queue has room for two words.
// Reset: stops playback, rewinds to step 15, clears the pattern and the
// sounding note, sets the base note to 60 and empties the queue.
// When the receiver stalls, the queue fills, the core holds its word and
// i_item.ready drops; nothing is lost.
module midi_step_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mss_in_if.sink       i_item,
    mss_cfg_if.sink      i_cfg,
    mss_out_if.source    o_result
);

    mss_pkg::t_push      push;
    logic                space;

    mss_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (i_cfg),
        .i_space (space),
        .o_push  (push)
    );

    mss_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_result (o_result)
    );

endmodule

// ----- rtl/mss_core.sv -----
// Sequencer core: input register, pattern store, playback state and the
// single-pass result logic. Depends on mss_pkg and mss_ifs.
module mss_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mss_in_if.sink                      i_item,
    mss_cfg_if.sink                     i_cfg,
    input  logic                        i_space,
    output mss_pkg::t_push              o_push
);

    function automatic logic [mss_pkg::POSITION_W-1:0] rep_pos(
        input logic [mss_pkg::POS_W-1:0] pos
    );
        logic [mss_pkg::POS_EXT_W-1:0] ext;
        ext = mss_pkg::POS_EXT_W'(pos);
        return ext[mss_pkg::POSITION_W-1:0];
    endfunction

    logic                               r_in_valid;
    mss_pkg::t_item                     r_in;
    logic [mss_pkg::NOTE_W-1:0]         r_base;
    logic signed [mss_pkg::OFFSET_W-1:0] r_offs [mss_pkg::NUM_STEPS];
    logic                               r_gates [mss_pkg::NUM_STEPS];
    logic [mss_pkg::POS_W-1:0]          r_pos;
    logic [mss_pkg::NOTE_W-1:0]         r_snd;
    logic                               r_active;
    logic                               r_running;

    logic                               fire;
    logic                               do_adv;
    logic                               do_sil;
    logic                               do_stop;
    logic                               do_rewind;
    logic                               do_wr;
    logic [mss_pkg::POS_W:0]            pos_inc;
    logic [mss_pkg::POS_W-1:0]          adv_pos;
    logic signed [mss_pkg::SUM_W-1:0]   sum;
    logic [mss_pkg::NOTE_W-1:0]         clamped;
    logic [mss_pkg::SIDX_EXT_W-1:0]     sidx_ext;
    logic [mss_pkg::POS_W-1:0]          wr_idx;
    mss_pkg::t_result                   off_res;
    mss_pkg::t_result                   adv_res;
    mss_pkg::t_result                   mark_res;
    mss_pkg::t_push                     n_push;

    // Take a new word when none is held or the held one moves on
    assign fire          = r_in_valid && i_space;
    assign i_item.ready  = !r_in_valid || i_space;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.valid && i_item.ready) begin
            r_in.func        <= i_item.func;
            r_in.step_index  <= i_item.step_index;
            r_in.note_offset <= i_item.note_offset;
            r_in.gate_in     <= i_item.gate_in;
        end
    end

    // Decode the held word
    always_comb begin
        do_adv    = 1'b0;
        do_sil    = 1'b0;
        do_stop   = 1'b0;
        do_rewind = 1'b0;
        do_wr     = 1'b0;
        unique case (r_in.func)
            mss_pkg::FN_TICK: begin
                do_adv = r_running;
                do_sil = r_running;
            end
            mss_pkg::FN_PLAY: begin
                do_adv = !r_running;
                do_sil = !r_running;
            end
            mss_pkg::FN_STOP: begin
                do_sil  = 1'b1;
                do_stop = 1'b1;
            end
            mss_pkg::FN_RESET: begin
                do_sil    = 1'b1;
                do_stop   = 1'b1;
                do_rewind = 1'b1;
            end
            mss_pkg::FN_WRITE: begin
                do_wr = 32'(r_in.step_index) < mss_pkg::NUM_STEPS;
            end
            default: begin
            end
        endcase
    end

    // Advance with wraparound and form the clamped note of the new step
    assign pos_inc  = {1'b0, r_pos} + (mss_pkg::POS_W + 1)'(1);
    assign adv_pos  = (pos_inc >= (mss_pkg::POS_W + 1)'(mss_pkg::NUM_STEPS))
                      ? '0 : pos_inc[mss_pkg::POS_W-1:0];
    assign sum      = $signed({2'b00, r_base}) + $signed({r_offs[adv_pos][mss_pkg::OFFSET_W-1],
                                                          r_offs[adv_pos]});
    assign sidx_ext = mss_pkg::SIDX_EXT_W'(r_in.step_index);
    assign wr_idx   = sidx_ext[mss_pkg::POS_W-1:0];

    always_comb begin
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > $signed(mss_pkg::SUM_W'(mss_pkg::NOTE_MAX))) begin
            clamped = mss_pkg::NOTE_MAX;
        end else begin
            clamped = sum[mss_pkg::NOTE_W-1:0];
        end
    end

    // Build the candidate results
    always_comb begin
        off_res.msg_kind     = mss_pkg::KIND_OFF;
        off_res.note         = r_snd;
        off_res.position     = rep_pos(r_pos);
        off_res.last_of_run  = 1'b0;

        adv_res.msg_kind     = r_gates[adv_pos] ? mss_pkg::KIND_ON : mss_pkg::KIND_MARK;
        adv_res.note         = r_gates[adv_pos] ? clamped : '0;
        adv_res.position     = rep_pos(adv_pos);
        adv_res.last_of_run  = 1'b1;

        mark_res.msg_kind    = mss_pkg::KIND_MARK;
        mark_res.note        = '0;
        mark_res.position    = '0;
        mark_res.last_of_run = 1'b1;
    end

    // Order the results: note-off first, then the step result or the reset marker
    always_comb begin
        n_push.count = 2'd0;
        n_push.res0  = adv_res;
        n_push.res1  = adv_res;
        if (fire) begin
            if (do_sil && r_active) begin
                n_push.res0 = off_res;
                if (do_adv) begin
                    n_push.count = 2'd2;
                end else if (do_rewind) begin
                    n_push.count = 2'd2;
                    n_push.res1  = mark_res;
                end else begin
                    n_push.count            = 2'd1;
                    n_push.res0.last_of_run = 1'b1;
                end
            end else if (do_adv) begin
                n_push.count = 2'd1;
            end else if (do_rewind) begin
                n_push.count = 2'd1;
                n_push.res0  = mark_res;
            end
        end
    end

    assign o_push = n_push;

    // Update playback state, pattern and base note
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= mss_pkg::POS_W'(mss_pkg::NUM_STEPS - 1);
            r_snd     <= '0;
            r_active  <= 1'b0;
            r_running <= 1'b0;
            r_base    <= mss_pkg::BASE_RESET;
            for (int i = 0; i < mss_pkg::NUM_STEPS; i++) begin
                r_offs[i]  <= '0;
                r_gates[i] <= 1'b0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_base <= i_cfg.base_note;
            end
            if (fire) begin
                if (do_sil) begin
                    r_active <= 1'b0;
                    r_snd    <= '0;
                end
                if (do_adv) begin
                    r_running <= 1'b1;
                    r_pos     <= adv_pos;
                    if (r_gates[adv_pos]) begin
                        r_active <= 1'b1;
                        r_snd    <= clamped;
                    end
                end
                if (do_stop) begin
                    r_running <= 1'b0;
                end
                if (do_rewind) begin
                    r_pos <= mss_pkg::POS_W'(mss_pkg::NUM_STEPS - 1);
                end
                if (do_wr) begin
                    r_offs[wr_idx]  <= r_in.note_offset;
                    r_gates[wr_idx] <= r_in.gate_in;
                end
            end
        end
    end

endmodule

// ----- rtl/mss_outq.sv -----
// Result queue: takes up to two result words a cycle from the core and
// hands them out one at a time. Depends on mss_pkg and mss_ifs.
module mss_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mss_pkg::t_push        i_push,
    output logic                  o_space,
    mss_out_if.source             o_result
);

    mss_pkg::t_result             r_mem [mss_pkg::Q_DEPTH];
    logic [mss_pkg::Q_AW-1:0]     r_head;
    logic [mss_pkg::Q_AW-1:0]     r_tail;
    logic [mss_pkg::Q_CW-1:0]     r_cnt;
    logic [mss_pkg::Q_CW-1:0]     n_cnt;
    logic                         pop;
    logic [mss_pkg::Q_AW-1:0]     tail_nx;

    assign pop     = o_result.valid && o_result.ready;
    assign tail_nx = r_tail + mss_pkg::Q_AW'(1);

    // Room for two words once this cycle's pop is done
    assign o_space = (r_cnt <= mss_pkg::Q_CW'(mss_pkg::Q_DEPTH - 2))
                     || ((r_cnt == mss_pkg::Q_CW'(mss_pkg::Q_DEPTH - 1)) && pop);

    assign n_cnt = r_cnt - mss_pkg::Q_CW'(pop) + mss_pkg::Q_CW'(i_push.count);

    // Drive the head word
    assign o_result.valid       = (r_cnt != '0);
    assign o_result.msg_kind    = r_mem[r_head].msg_kind;
    assign o_result.note        = r_mem[r_head].note;
    assign o_result.position    = r_mem[r_head].position;
    assign o_result.last_of_run = r_mem[r_head].last_of_run;

    // Hold the words
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_nx] <= i_push.res1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_tail <= r_tail + mss_pkg::Q_AW'(i_push.count);
            if (pop) begin
                r_head <= r_head + mss_pkg::Q_AW'(1);
            end
        end
    end

endmodule

// ----- rtl/mss_check.sv -----
// Port-level checks for the MIDI step sequencer, bound to the top level.
// Depends on mss_pkg.
module mss_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [mss_pkg::KIND_W-1:0]        i_msg_kind,
    input logic [mss_pkg::NOTE_W-1:0]        i_note,
    input logic [mss_pkg::POSITION_W-1:0]    i_position,
    input logic                              i_last_of_run
);

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_msg_kind)
            && $stable(i_note) && $stable(i_position) && $stable(i_last_of_run))
        else $error("result word changed while stalled");

    // Nothing leaves right after reset
    a_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A marker carries no note
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_msg_kind == mss_pkg::KIND_MARK |-> i_note == '0)
        else $error("step marker with a note");

    // A note-off that does not end its run is followed at once by its partner
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_msg_kind == mss_pkg::KIND_OFF && !i_last_of_run
            |=> i_out_valid && i_msg_kind != mss_pkg::KIND_OFF && i_last_of_run)
        else $error("note-off not followed by its step result");

endmodule

bind midi_step_sequencer mss_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_msg_kind    (o_result.msg_kind),
    .i_note        (o_result.note),
    .i_position    (o_result.position),
    .i_last_of_run (o_result.last_of_run)
);

// ----- tb/tb_midi_step_sequencer.sv -----
// Self-checking testbench for midi_step_sequencer: drives command words, checks
// result words against a cycle-free predictor of the sequencer.
// Depends on mss_pkg, mss_ifs and the midi_step_sequencer RTL.
module tb_midi_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_WORDS   = 205;
    localparam int FUNC_LAST     = 2**mss_pkg::FUNC_W - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mss_in_if  item_if ();
    mss_cfg_if cfg_if ();
    mss_out_if res_if ();

    midi_step_sequencer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sequencer state as the predictor sees it
    logic signed [mss_pkg::OFFSET_W-1:0] pat_offset [mss_pkg::NUM_STEPS];
    logic                                pat_gate   [mss_pkg::NUM_STEPS];
    logic [mss_pkg::POS_W-1:0]           play_pos;
    logic [mss_pkg::NOTE_W-1:0]          held_note;
    logic                                note_held;
    logic                                is_playing;
    logic [mss_pkg::NOTE_W-1:0]          base_note_now;

    mss_pkg::t_result expected_msgs [$];
    mss_pkg::t_item   pending_words [$];
    mss_pkg::t_item   word_on_bus;

    int  errors;
    int  words_sent;
    int  msgs_checked;
    int  base_writes;
    int  burst_left;
    int  gap_left;
    int  pat_hold;
    int  quiet_cycles;
    bit  gen_playing;
    logic [15:0] ready_pat;

    function automatic void reset_model();
        for (int i = 0; i < mss_pkg::NUM_STEPS; i++) begin
            pat_offset[i] = '0;
            pat_gate[i]   = 1'b0;
        end
        play_pos      = mss_pkg::POS_W'(mss_pkg::NUM_STEPS - 1);
        held_note     = '0;
        note_held     = 1'b0;
        is_playing    = 1'b0;
        base_note_now = mss_pkg::BASE_RESET;
    endfunction

    function automatic void queue_msg(logic [mss_pkg::KIND_W-1:0] kind,
                                      logic [mss_pkg::NOTE_W-1:0] nt,
                                      logic [mss_pkg::POSITION_W-1:0] pos);
        mss_pkg::t_result r;
        r.msg_kind    = kind;
        r.note        = nt;
        r.position    = pos;
        r.last_of_run = 1'b0;
        expected_msgs.push_back(r);
    endfunction

    // End the sounding note at the position held before any advance
    function automatic void silence_note();
        if (note_held) begin
            queue_msg(mss_pkg::KIND_OFF, held_note, mss_pkg::POSITION_W'(play_pos));
            note_held = 1'b0;
            held_note = '0;
        end
    endfunction

    // Advance with wraparound, then sound the step or mark it
    function automatic void step_forward();
        int n;
        silence_note();
        play_pos = (int'(play_pos) + 1 >= mss_pkg::NUM_STEPS) ? '0 : play_pos + 1'b1;
        if (pat_gate[play_pos]) begin
            n = int'(base_note_now) + int'(pat_offset[play_pos]);
            if (n < 0)
                n = 0;
            if (n > int'(mss_pkg::NOTE_MAX))
                n = int'(mss_pkg::NOTE_MAX);
            held_note = mss_pkg::NOTE_W'(n);
            note_held = 1'b1;
            queue_msg(mss_pkg::KIND_ON, held_note, mss_pkg::POSITION_W'(play_pos));
        end else begin
            queue_msg(mss_pkg::KIND_MARK, '0, mss_pkg::POSITION_W'(play_pos));
        end
    endfunction

    function automatic void predict_word(mss_pkg::t_item it);
        int               before_cnt;
        mss_pkg::t_result r;
        before_cnt = expected_msgs.size();
        case (it.func)
            mss_pkg::FN_TICK: begin
                if (is_playing)
                    step_forward();
            end
            mss_pkg::FN_PLAY: begin
                if (!is_playing) begin
                    is_playing = 1'b1;
                    step_forward();
                end
            end
            mss_pkg::FN_STOP: begin
                silence_note();
                is_playing = 1'b0;
            end
            mss_pkg::FN_RESET: begin
                silence_note();
                is_playing = 1'b0;
                play_pos   = mss_pkg::POS_W'(mss_pkg::NUM_STEPS - 1);
                queue_msg(mss_pkg::KIND_MARK, '0, '0);
            end
            mss_pkg::FN_WRITE: begin
                if (int'(it.step_index) < mss_pkg::NUM_STEPS) begin
                    pat_offset[it.step_index[mss_pkg::POS_W-1:0]] = it.note_offset;
                    pat_gate[it.step_index[mss_pkg::POS_W-1:0]]   = it.gate_in;
                end
            end
            default: ;
        endcase
        // Flag the final word of this command
        if (expected_msgs.size() > before_cnt) begin
            r = expected_msgs.pop_back();
            r.last_of_run = 1'b1;
            expected_msgs.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic mss_pkg::t_item make_word(logic [mss_pkg::FUNC_W-1:0] f, int idx,
                                                 int off, bit gate);
        mss_pkg::t_item it;
        it.func        = f;
        it.step_index  = mss_pkg::SIDX_W'(idx);
        it.note_offset = mss_pkg::OFFSET_W'(off);
        it.gate_in     = gate;
        return it;
    endfunction

    // Command driver: bursts of random length with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            item_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                predict_word(word_on_bus);
                words_sent++;
            end
            // Hold the word while it is stalled
            if (!(item_if.valid && !item_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_if.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    word_on_bus = pending_words.pop_front();
                    item_if.func        <= word_on_bus.func;
                    item_if.step_index  <= word_on_bus.step_index;
                    item_if.note_offset <= word_on_bus.note_offset;
                    item_if.gate_in     <= word_on_bus.gate_in;
                    item_if.valid       <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, stall on a rotating pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            ready_pat = '1;
            pat_hold  = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_msgs.size() == 0) begin
                    $error("unexpected result: kind %0d note %0d position %0d last %0d",
                           res_if.msg_kind, res_if.note, res_if.position,
                           res_if.last_of_run);
                    errors++;
                end else begin
                    mss_pkg::t_result e;
                    e = expected_msgs.pop_front();
                    check_field("msg_kind", e.msg_kind, res_if.msg_kind);
                    check_field("note", e.note, res_if.note);
                    check_field("position", e.position, res_if.position);
                    check_field("last_of_run", e.last_of_run, res_if.last_of_run);
                    msgs_checked++;
                end
            end
            if (pat_hold == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = '1;
                    1:       ready_pat = 16'($urandom) | 16'h1;
                    2:       ready_pat = 16'($urandom & $urandom) | 16'h1;
                    default: ready_pat = 16'($urandom | $urandom) | 16'h1;
                endcase
                pat_hold = $urandom_range(8, 96);
            end else begin
                ready_pat = {ready_pat[0], ready_pat[15:1]};
                pat_hold--;
            end
            res_if.ready <= ready_pat[0];
        end
    end

    // Watchdog: end the run when no channel moves a word for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_midi_step_sequencer: FAIL");
                $finish;
            end
        end
    end

    task automatic write_base(input logic [mss_pkg::NOTE_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.base_note <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        base_note_now = v;
        base_writes++;
    endtask

    // Wait until every word is sent and every result is back, then let the core settle
    task automatic drain();
        while (pending_words.size() > 0 || item_if.valid || expected_msgs.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly playback with pattern edits; stray ticks, plays and spare codes as noise
    task automatic queue_random(input int target);
        mss_pkg::t_item it;
        int             counted;
        int             pick;
        counted = 0;
        while (counted < target) begin
            it.step_index  = mss_pkg::SIDX_W'($urandom);
            it.note_offset = mss_pkg::OFFSET_W'($urandom);
            it.gate_in     = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (gen_playing) begin
                if (pick < 55)      it.func = mss_pkg::FN_TICK;
                else if (pick < 60) it.func = mss_pkg::FN_PLAY;
                else if (pick < 64) it.func = mss_pkg::FN_STOP;
                else if (pick < 67) it.func = mss_pkg::FN_RESET;
                else if (pick < 97) it.func = mss_pkg::FN_WRITE;
                else it.func = mss_pkg::FUNC_W'($urandom_range(mss_pkg::FN_WRITE + 1,
                                                               FUNC_LAST));
            end else begin
                if (pick < 35)      it.func = mss_pkg::FN_PLAY;
                else if (pick < 45) it.func = mss_pkg::FN_TICK;
                else if (pick < 70) it.func = mss_pkg::FN_WRITE;
                else if (pick < 80) it.func = mss_pkg::FN_RESET;
                else if (pick < 88) it.func = mss_pkg::FN_STOP;
                else it.func = mss_pkg::FUNC_W'($urandom_range(mss_pkg::FN_WRITE + 1,
                                                               FUNC_LAST));
            end
            if (it.func == mss_pkg::FN_WRITE) begin
                it.step_index = ($urandom_range(0, 9) != 0) ?
                    mss_pkg::SIDX_W'($urandom_range(0, mss_pkg::NUM_STEPS - 1)) :
                    mss_pkg::SIDX_W'($urandom_range(mss_pkg::NUM_STEPS,
                                                    2**mss_pkg::SIDX_W - 1));
                if ($urandom_range(0, 4) < 3)
                    it.note_offset = mss_pkg::OFFSET_W'(int'($urandom_range(0, 40)) - 20);
                it.gate_in = ($urandom_range(0, 9) < 7);
            end
            case (it.func)
                mss_pkg::FN_TICK:  if (gen_playing) counted++;
                mss_pkg::FN_PLAY: begin
                    if (!gen_playing) counted++;
                    gen_playing = 1'b1;
                end
                mss_pkg::FN_STOP, mss_pkg::FN_RESET: begin
                    counted++;
                    gen_playing = 1'b0;
                end
                mss_pkg::FN_WRITE: if (int'(it.step_index) < mss_pkg::NUM_STEPS) counted++;
                default: ;
            endcase
            pending_words.push_back(it);
        end
    endtask

    initial begin
        logic [mss_pkg::NOTE_W-1:0] bases [8];

        item_if.valid       = 1'b0;
        item_if.func        = mss_pkg::FN_TICK;
        item_if.step_index  = '0;
        item_if.note_offset = '0;
        item_if.gate_in     = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.base_note    = mss_pkg::BASE_RESET;
        res_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        errors       = 0;
        words_sent   = 0;
        msgs_checked = 0;
        base_writes  = 0;
        quiet_cycles = 0;
        gen_playing  = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_base(mss_pkg::BASE_RESET);

        // Directed: ignored commands, clamping at both ends, out-of-range writes,
        // stop and reset with and without a sounding note
        pending_words.push_back(make_word(mss_pkg::FN_TICK, 31, -1, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_STOP, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, 0, 127, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, 1, -128, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, 2, 5, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, mss_pkg::NUM_STEPS, 1, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, 2**mss_pkg::SIDX_W - 1, -1,
                                          1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_WRITE, mss_pkg::NUM_STEPS - 1, 0,
                                          1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_PLAY, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_PLAY, 31, -1, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_TICK, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_TICK, 0, 0, 1'b0));
        for (int f = mss_pkg::FN_WRITE + 1; f <= FUNC_LAST; f++)
            pending_words.push_back(make_word(mss_pkg::FUNC_W'(f), 3, 9, 1'b1));
        pending_words.push_back(make_word(mss_pkg::FN_STOP, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_RESET, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_PLAY, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_STOP, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_PLAY, 0, 0, 1'b0));
        pending_words.push_back(make_word(mss_pkg::FN_RESET, 0, 0, 1'b0));
        drain();

        // Random phases, each under its own base note
        bases[0] = '0;
        bases[1] = mss_pkg::NOTE_MAX;
        bases[2] = mss_pkg::NOTE_W'($urandom);
        bases[3] = mss_pkg::NOTE_W'(1);
        bases[4] = mss_pkg::NOTE_MAX - 1'b1;
        bases[5] = mss_pkg::NOTE_W'($urandom);
        bases[6] = mss_pkg::NOTE_W'($urandom);
        bases[7] = mss_pkg::BASE_RESET;
        foreach (bases[p]) begin
            write_base(bases[p]);
            queue_random(PHASE_WORDS);
            drain();
        end

        $display("Sent %0d command words, checked %0d result words", words_sent, msgs_checked);
        $display("across %0d base-note settings including both extremes", base_writes);
        if (errors == 0)
            $display("tb_midi_step_sequencer: PASS");
        else
            $display("tb_midi_step_sequencer: FAIL");
        $finish;
    end

endmodule

// ----- midi_step_sequencer.f -----
rtl/mss_pkg.sv
rtl/mss_ifs.sv
rtl/mss_core.sv
rtl/mss_outq.sv
rtl/midi_step_sequencer.sv
rtl/mss_check.sv
tb/tb_midi_step_sequencer.sv
